// File: rtl/core/dptf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dptf_pkg
// Shared types, constants and date helpers of the dated price table.
// ---------------------------------------------------------------------------
package dptf_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 7;
  localparam int DAY_W    = 7;
  localparam int PRICE_W  = 48;
  localparam int AMOUNT_W = 32;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 58;
  localparam int KEY_W    = 23;
  localparam int LIMIT_W  = 15;
  localparam int PROD_W   = 63;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1000;
  localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'd9999;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};
  localparam logic [12:0]        RECIP_100   = 13'd5243;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DATE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_AMOUNT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_EARLIER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [3:0] MONTH_FEB = 4'd2;

  typedef struct packed {
    logic cap;
    logic scan_start;
    logic scan_run;
    logic write;
    logic mul_hi;
    logic mul_lo;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic date_ok;
    logic amt_ok;
    logic func;
    logic scan_done;
    logic found;
    logic out_busy;
  } dp_sts_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [14:0] qx;
    logic [YEAR_W-1:0] r;
    prod = year * RECIP_100;
    q    = prod[26:19];
    qx   = q * 7'd100;
    r    = year - qx[YEAR_W-1:0];
    return (year[1:0] == 2'd0) && ((r != '0) || (q[1:0] == 2'd0));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/dptf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dptf_ctrl
// Sequencer: check, table scan, write back or multiply, result transfer.
// ---------------------------------------------------------------------------
module dptf_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  dptf_pkg::dp_sts_t  sts,
  output dptf_pkg::dp_cmd_t  cmd
);
  import dptf_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_WRITE = 7'b0001000,
    S_MULH  = 7'b0010000,
    S_MULL  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.date_ok || (sts.func == FUNC_QUERY && !sts.amt_ok)) begin
          state_nxt = S_DONE;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.func == FUNC_LOAD) state_nxt = S_WRITE;
          else if (sts.found)        state_nxt = S_MULH;
          else                       state_nxt = S_DONE;
        end
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = S_DONE;
      end
      S_MULH: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = S_MULL;
      end
      S_MULL: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/core/dptf_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dptf_dp
// Datapath: item capture, date and amount check, table memory scan, multiply, output.
// ---------------------------------------------------------------------------
module dptf_dp #(
  parameter int TABLE_DEPTH = dptf_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_func,
  input  wire  [dptf_pkg::YEAR_W-1:0]         in_year,
  input  wire  [dptf_pkg::MONTH_W-1:0]        in_month,
  input  wire  [dptf_pkg::DAY_W-1:0]          in_day,
  input  wire  [dptf_pkg::PRICE_W-1:0]        in_price,
  input  wire  signed [dptf_pkg::AMOUNT_W-1:0] in_amount,
  input  wire  [dptf_pkg::LIMIT_W-1:0]        amount_limit,
  input  dptf_pkg::dp_cmd_t                   cmd,
  output dptf_pkg::dp_sts_t                   sts,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [dptf_pkg::STATUS_W-1:0]       out_status,
  output logic [dptf_pkg::TOTAL_W-1:0]        out_total
);
  import dptf_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [KEY_W-1:0]   date_mem [TABLE_DEPTH];
  logic [PRICE_W-1:0] price_mem [TABLE_DEPTH];

  logic               func_r;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DAY_W-1:0]   day_r;
  logic [PRICE_W-1:0] price_r;
  logic [AMOUNT_W-1:0] amt_r;

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;
  logic               pend_r;
  logic [IW-1:0]      pend_idx_r;
  logic [KEY_W-1:0]   rd_date_r;
  logic [PRICE_W-1:0] rd_price_r;
  logic               found_r, match_r;
  logic               wr_full_r;
  logic [IW-1:0]      match_idx_r;
  logic [KEY_W-1:0]   best_key_r;
  logic [PRICE_W-1:0] best_price_r;
  logic [PROD_W-1:0]  prod_hi_r, prod_lo_r;
  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [TOTAL_W-1:0] out_total_r;

  logic               date_ok, amt_ok, full, issue;
  logic [KEY_W-1:0]   key;
  logic [31:0]        mul_b;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W:0]    sum;
  logic [STATUS_W-1:0] status_sel;
  logic [TOTAL_W-1:0] total_sel;

  assign date_ok = (year_r <= YEAR_MAX) && (month_r >= 7'd1) && (month_r <= 7'd12) &&
                   (day_r >= 7'd1) &&
                   (day_r <= {2'b0, month_len(month_r[3:0], is_leap(year_r))});
  assign amt_ok  = !amt_r[AMOUNT_W-1] &&
                   ({1'b0, amt_r} <= {2'b0, amount_limit, 16'b0});
  assign key     = {year_r, month_r[3:0], day_r[4:0]};
  assign full    = (count_r >= DEPTH_C);
  assign issue   = cmd.scan_run && (idx_r < count_r);

  assign sts.date_ok   = date_ok;
  assign sts.amt_ok    = amt_ok;
  assign sts.func      = func_r;
  assign sts.scan_done = (idx_r >= count_r) && !pend_r;
  assign sts.found     = found_r;
  assign sts.out_busy  = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      func_r  <= in_func;
      year_r  <= in_year;
      month_r <= in_month;
      day_r   <= in_day;
      price_r <= in_price;
      amt_r   <= in_amount;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_date_r  <= date_mem[idx_r[IW-1:0]];
      rd_price_r <= price_mem[idx_r[IW-1:0]];
    end
    if (cmd.write && (match_r || !full)) begin
      date_mem[match_r ? match_idx_r : count_r[IW-1:0]]  <= key;
      price_mem[match_r ? match_idx_r : count_r[IW-1:0]] <= price_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      if (cmd.write && !match_r && !full) count_r <= count_r + 1'b1;
      if (cmd.scan_start) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
      end else if (cmd.scan_run) begin
        if (issue) idx_r <= idx_r + 1'b1;
        pend_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) pend_idx_r <= idx_r[IW-1:0];
    if (cmd.write) wr_full_r <= full && !match_r;
    if (cmd.scan_start) begin
      found_r <= 1'b0;
      match_r <= 1'b0;
    end else if (pend_r) begin
      if (rd_date_r == key) begin
        match_r     <= 1'b1;
        match_idx_r <= pend_idx_r;
      end
      if ((rd_date_r <= key) && (!found_r || rd_date_r > best_key_r)) begin
        found_r      <= 1'b1;
        best_key_r   <= rd_date_r;
        best_price_r <= rd_price_r;
      end
    end
  end

  assign mul_b = cmd.mul_hi ? best_price_r[PRICE_W-1:16] : {16'b0, best_price_r[15:0]};
  assign prod  = {32'b0, amt_r[30:0]} * {31'b0, mul_b};
  assign sum   = {1'b0, prod_hi_r} + {17'b0, prod_lo_r[PROD_W-1:16]};

  always_ff @(posedge clk) begin
    if (cmd.mul_hi) prod_hi_r <= prod;
    if (cmd.mul_lo) prod_lo_r <= prod;
  end

  always_comb begin
    status_sel = ST_OK;
    total_sel  = '0;
    if (!date_ok) begin
      status_sel = ST_BAD_DATE;
    end else if (func_r == FUNC_LOAD) begin
      if (wr_full_r) status_sel = ST_FULL;
    end else if (!amt_ok) begin
      status_sel = ST_BAD_AMOUNT;
    end else if (!found_r) begin
      status_sel = ST_NO_EARLIER;
    end else begin
      total_sel = (sum > {6'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_sel;
      out_total_r  <= total_sel;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_total  = out_total_r;

endmodule
`default_nettype wire

// File: rtl/core/dated_price_table_floor_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// dated_price_table_floor_lookup_unit
// Dated price table with exact-date load and floor-date query.
// ---------------------------------------------------------------------------
// One item is in flight at a time. An item with a bad date or a bad query
// amount goes from the check straight to the result; any other item scans
// the stored entries through the table memory read port, one entry per
// cycle, then writes the entry for a load (unless the table is full and the
// date is new) or runs the high and low multiply steps for a query that
// finds a date. The table holds at most TABLE_DEPTH entries. A new item is
// taken once the previous result has moved into the output register.
// ---------------------------------------------------------------------------
module dated_price_table_floor_lookup_unit #(
  parameter int TABLE_DEPTH = dptf_pkg::TABLE_DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_func,
  input  wire  [dptf_pkg::YEAR_W-1:0]          in_year,
  input  wire  [dptf_pkg::MONTH_W-1:0]         in_month,
  input  wire  [dptf_pkg::DAY_W-1:0]           in_day,
  input  wire  [dptf_pkg::PRICE_W-1:0]         in_price,
  input  wire  signed [dptf_pkg::AMOUNT_W-1:0] in_amount,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [dptf_pkg::STATUS_W-1:0]        out_status,
  output logic [dptf_pkg::TOTAL_W-1:0]         out_total,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [0:0]                           paddr,
  input  wire  [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import dptf_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  dp_cmd_t cmd;
  dp_sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {17'b0, limit_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == 1'b0) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  dptf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  dptf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_func      (in_func),
    .in_year      (in_year),
    .in_month     (in_month),
    .in_day       (in_day),
    .in_price     (in_price),
    .in_amount    (in_amount),
    .amount_limit (limit_r),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_total    (out_total)
  );

endmodule
`default_nettype wire
